@@ src/rlpm_pkg.sv @@
// Package for the router liveness ping monitor.
// Holds widths, operation and result codes and the entry record type.
// No dependencies.
package rlpm_pkg;
	localparam int RouterCount = 16;
	localparam int IdxBits = 4;
	localparam int TimeBits = 32;

	localparam logic [2:0] OpTick = 3'd0;
	localparam logic [2:0] OpPingSent = 3'd1;
	localparam logic [2:0] OpPingReply = 3'd2;
	localparam logic [2:0] OpNotify = 3'd3;
	localparam logic [2:0] OpPresence = 3'd4;

	localparam logic [2:0] KindDone = 3'd0;
	localparam logic [2:0] KindNotify = 3'd1;
	localparam logic [2:0] KindPing = 3'd2;
	localparam logic [2:0] KindFuture = 3'd3;
	localparam logic [2:0] KindIgnored = 3'd4;

	localparam logic [2:0] RegLive = 3'd0;
	localparam logic [2:0] RegDead = 3'd1;
	localparam logic [2:0] RegTimeout = 3'd2;
	localparam logic [2:0] RegAutoDown = 3'd3;
	localparam logic [2:0] RegStartDown = 3'd4;

	typedef struct packed {
		logic present;
		logic alive;
		logic known;
		logic [TimeBits-1:0] news;
		logic [TimeBits-1:0] deadline;
		logic [TimeBits-1:0] last_ping;
		logic outstanding;
		logic [1:0] pending;
	} entry_t;

	// One result word headed for the output ports.
	typedef struct packed {
		logic valid;
		logic [2:0] kind;
		logic [IdxBits-1:0] router;
		logic alive;
		logic last;
	} res_t;
endpackage

@@ src/rlpm_unit.sv @@
// Shared entry update unit: applies one step of an operation to one entry.
// Depends on rlpm_pkg.
module rlpm_unit (
	input logic [2:0] op,
	input logic [rlpm_pkg::TimeBits-1:0] now,
	input logic [rlpm_pkg::TimeBits-1:0] when_t,
	input logic alive_news,
	input logic from_driver,
	input logic status_ok,
	input logic [15:0] live_iv,
	input logic [15:0] dead_iv,
	input logic [15:0] timeout,
	input rlpm_pkg::entry_t ent_in,
	output rlpm_pkg::entry_t ent_out,
	output logic emit_notify,
	output logic notify_alive,
	output logic emit_ping
);
	localparam int TB = rlpm_pkg::TimeBits;
	rlpm_pkg::entry_t e;
	logic news_v, news_drv, news_alive;
	logic [TB-1:0] news_when, secs, dsum;
	logic [TB:0] sum;

	always_comb begin
		e = ent_in;
		emit_notify = 1'b0;
		notify_alive = 1'b0;
		emit_ping = 1'b0;
		news_v = 1'b0;
		news_drv = 1'b1;
		news_alive = 1'b0;
		news_when = now;
		secs = '0;
		sum = {1'b0, now} + {{(TB-15){1'b0}}, timeout};
		dsum = sum[TB] ? {TB{1'b1}} : sum[TB-1:0];
		// Decide which news this step carries.
		case (op)
			rlpm_pkg::OpTick: begin
				news_v = (e.deadline != '0) && (now > e.deadline);
			end
			rlpm_pkg::OpPingSent: begin
				e.outstanding = 1'b0;
				news_v = !status_ok;
			end
			rlpm_pkg::OpPingReply: begin
				news_v = 1'b1;
				news_alive = status_ok;
			end
			rlpm_pkg::OpNotify: begin
				news_v = 1'b1;
				news_drv = !from_driver;
				news_alive = alive_news;
				news_when = when_t;
			end
			default: news_v = 1'b0;
		endcase
		// Take the news unless it is stale or repeats the known state.
		if (news_v && news_when >= e.news) begin
			e.news = news_when;
			e.deadline = '0;
			if (!(e.known && e.alive == news_alive)) begin
				e.known = 1'b1;
				e.alive = news_alive;
				e.pending = {e.pending[1] | news_drv, 1'b1};
			end
		end
		// Flush the pending notification on tick and notify.
		if ((op == rlpm_pkg::OpTick || op == rlpm_pkg::OpNotify) && e.pending[0]) begin
			emit_notify = e.pending[1];
			notify_alive = e.alive;
			e.pending = 2'b00;
		end
		// Ping request once the interval has elapsed.
		if (op == rlpm_pkg::OpTick) begin
			secs = e.alive ? {{(TB-16){1'b0}}, live_iv} : {{(TB-16){1'b0}}, dead_iv};
			if (secs != '0 && !e.outstanding && now > e.last_ping
					&& (now - e.last_ping) > secs) begin
				emit_ping = 1'b1;
				e.outstanding = 1'b1;
				e.last_ping = now;
				if (e.deadline == '0) e.deadline = dsum;
			end
		end
		ent_out = e;
	end
endmodule

@@ src/router_liveness_ping_monitor.sv @@
// Top level of the router liveness ping monitor: sequencer, entry table, ports.
// Depends on rlpm_pkg and rlpm_unit.
//
// Channel   | Handshake       | Words
// ----------+-----------------+---------------------------------------------
// input     | start / busy    | operation, router_index, times, flags
// result    | result_valid    | result_kind, result_router, result_alive, last
// config    | cfg_we          | cfg_index, cfg_data
//
// A tick walks all sixteen entries from entry 0 through the shared update unit,
// one entry per cycle, plus a StPing step for every ping request, plus a closing
// StDone step that gives the last word. Other items hold busy for one cycle,
// and their single word is registered from the StStep state.
// The entry table resets to absent entries. The receiver cannot stall.
module router_liveness_ping_monitor (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [2:0] operation,
	input logic [3:0] router_index,
	input logic [31:0] now_seconds,
	input logic [31:0] when_seconds,
	input logic alive_news,
	input logic from_driver,
	input logic status_ok,
	input logic present_flag,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [15:0] cfg_data,
	output logic result_valid,
	output logic [2:0] result_kind,
	output logic [3:0] result_router,
	output logic result_alive,
	output logic last_result
);
	localparam int IB = rlpm_pkg::IdxBits;
	localparam logic [2:0] StIdle = 3'd0;
	localparam logic [2:0] StStep = 3'd1;
	localparam logic [2:0] StPing = 3'd2;
	localparam logic [2:0] StDone = 3'd3;

	rlpm_pkg::entry_t tab_q [rlpm_pkg::RouterCount];
	logic [15:0] live_q, dead_q, tmo_q;
	logic autodown_q, startdown_q;
	logic [2:0] st_q, op_q;
	logic [IB-1:0] idx_q;
	logic [31:0] now_q, when_q;
	logic alive_q, drv_q, ok_q, pres_q;
	rlpm_pkg::res_t res_q, hold_q;
	rlpm_pkg::entry_t ent_out;
	logic emit_n, n_alive, emit_p;
	logic [2:0] st_d;
	rlpm_pkg::res_t res_d, hold_d;
	logic tab_we;
	rlpm_pkg::entry_t tab_d;
	logic [2:0] one_kind;
	logic one_alive, one_wr;
	rlpm_pkg::entry_t one_ent;
	logic last_idx;

	rlpm_unit u_unit (
		.op(op_q), .now(now_q), .when_t(when_q), .alive_news(alive_q),
		.from_driver(drv_q), .status_ok(ok_q), .live_iv(live_q), .dead_iv(dead_q),
		.timeout(tmo_q), .ent_in(tab_q[idx_q]), .ent_out(ent_out),
		.emit_notify(emit_n), .notify_alive(n_alive), .emit_ping(emit_p)
	);

	assign busy = (st_q != StIdle);
	assign result_valid = res_q.valid;
	assign result_kind = res_q.kind;
	assign result_router = res_q.router;
	assign result_alive = res_q.alive;
	assign last_result = res_q.last;
	assign last_idx = (idx_q == IB'(rlpm_pkg::RouterCount - 1));

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0; dead_q <= '0; tmo_q <= 16'd50;
			autodown_q <= 1'b1; startdown_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rlpm_pkg::RegLive: live_q <= cfg_data;
				rlpm_pkg::RegDead: dead_q <= cfg_data;
				rlpm_pkg::RegTimeout: tmo_q <= cfg_data;
				rlpm_pkg::RegAutoDown: autodown_q <= cfg_data[0];
				rlpm_pkg::RegStartDown: startdown_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Input capture and entry pointer. A tick always starts its walk at entry 0.
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_q <= operation;
			idx_q <= (operation == rlpm_pkg::OpTick) ? {IB{1'b0}} : router_index;
			now_q <= now_seconds; when_q <= when_seconds;
			alive_q <= alive_news; drv_q <= from_driver;
			ok_q <= status_ok; pres_q <= present_flag;
		end else if (st_q == StStep && op_q == rlpm_pkg::OpTick
				&& !(tab_q[idx_q].present && emit_p)) begin
			idx_q <= idx_q + 1'b1;
		end else if (st_q == StPing) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// Result word and entry value of an item that addresses a single entry.
	always_comb begin
		one_kind = rlpm_pkg::KindIgnored;
		one_alive = 1'b0;
		one_wr = 1'b0;
		one_ent = ent_out;
		if (op_q == rlpm_pkg::OpPresence) begin
			one_kind = rlpm_pkg::KindDone;
			one_wr = !pres_q || !tab_q[idx_q].present;
			one_ent = '0;
			one_ent.present = pres_q;
			one_ent.alive = pres_q && !startdown_q;
		end else if (op_q == rlpm_pkg::OpNotify && when_q > now_q) begin
			one_kind = rlpm_pkg::KindFuture;
		end else if ((op_q == rlpm_pkg::OpNotify
				|| op_q == rlpm_pkg::OpPingSent
				|| op_q == rlpm_pkg::OpPingReply)
				&& tab_q[idx_q].present
				&& !(op_q == rlpm_pkg::OpNotify && drv_q && !alive_q && !autodown_q)) begin
			one_wr = 1'b1;
			one_kind = emit_n ? rlpm_pkg::KindNotify : rlpm_pkg::KindDone;
			one_alive = emit_n & n_alive;
		end
	end

	// Sequencer. During a tick the newest word is held back in hold_q, so that
	// the closing cycle can mark it as the last word of the item.
	always_comb begin
		st_d = st_q;
		res_d = '0;
		hold_d = hold_q;
		tab_we = 1'b0;
		tab_d = ent_out;
		unique case (st_q)
			StIdle: begin
				if (start) begin
					st_d = StStep;
					hold_d = '0;
				end
			end
			StStep: begin
				if (op_q == rlpm_pkg::OpTick) begin
					if (tab_q[idx_q].present) begin
						tab_we = 1'b1;
						if (emit_n) begin
							res_d = hold_q;
							hold_d = '{1'b1, rlpm_pkg::KindNotify, idx_q, n_alive, 1'b0};
						end
						if (emit_p) st_d = StPing;
					end
					if (!(tab_q[idx_q].present && emit_p) && last_idx)
						st_d = StDone;
				end else begin
					st_d = StIdle;
					res_d = '{1'b1, one_kind, idx_q, one_alive, 1'b1};
					tab_we = one_wr;
					tab_d = one_ent;
				end
			end
			StPing: begin
				// Ping request after any notify word of the same entry.
				res_d = hold_q;
				hold_d = '{1'b1, rlpm_pkg::KindPing, idx_q, 1'b0, 1'b0};
				st_d = last_idx ? StDone : StStep;
			end
			StDone: begin
				st_d = StIdle;
				if (hold_q.valid)
					res_d = '{1'b1, hold_q.kind, hold_q.router, hold_q.alive, 1'b1};
				else
					res_d = '{1'b1, rlpm_pkg::KindDone, {IB{1'b0}}, 1'b0, 1'b1};
			end
			default: st_d = StIdle;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= StIdle;
			res_q <= '0;
			hold_q <= '0;
			for (int i = 0; i < rlpm_pkg::RouterCount; i++) tab_q[i] <= '0;
		end else begin
			st_q <= st_d;
			res_q <= res_d;
			hold_q <= hold_d;
			if (tab_we) tab_q[idx_q] <= tab_d;
		end
	end

	// The final word of an item appears once the sequencer is idle again.
	a_last_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last_result) |-> (st_q == StIdle));
	// Words that are not final belong to a tick still in progress.
	a_more_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !last_result) |-> busy);
	// Only defined result kinds leave the block.
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result_kind <= rlpm_pkg::KindIgnored));
	// The sequencer stays within its four states.
	a_state_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q <= StDone);
endmodule
